/* rtl/core/plec_pkg.sv */
// constants and register codes for the piecewise linear error correction block
`default_nettype none

package plec_pkg;

  // configuration port geometry: seven registers at 8-byte spacing
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;
  localparam int CFG_OFS_W  = 3;
  localparam int CFG_IDX_W  = CFG_ADDR_W - CFG_OFS_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POINTS_USED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_0     = 3'd1;

  localparam int                    PTS_USED_W     = 3;
  localparam logic [PTS_USED_W-1:0] PTS_USED_RESET = 3'd6;

  // default calibration table, indicated and actual values in millinewtons
  localparam int RESET_SLOTS = 6;
  localparam int FIELD_MAX_W = 28;

  localparam logic [FIELD_MAX_W-1:0] PT_RESET_X [RESET_SLOTS] = '{
    28'd0, 28'd40000000, 28'd80000000, 28'd120000000, 28'd160000000, 28'd190000000
  };
  localparam logic [FIELD_MAX_W-1:0] PT_RESET_Y [RESET_SLOTS] = '{
    28'd0, 28'd39900000, 28'd79960000, 28'd120040000, 28'd160080000, 28'd190150000
  };

  // the same table as full register words, x in the upper 28 bits and y in the lower 28
  localparam logic [2*FIELD_MAX_W-1:0] PT_RESET_WORD [RESET_SLOTS] = '{
    56'd0, 56'd10737418279900000, 56'd21474836559960000,
    56'd32212254840040000, 56'd42949673120080000, 56'd51002736830150000
  };

endpackage

`default_nettype wire

/* rtl/core/piecewise_linear_error_correction_top.sv */
// piecewise linear error correction of a load reading, pipelined
// out_strobe follows the edge that accepts start through stages a, b, c, d and m, the divider
//   stages and the output register; one transaction can be accepted every cycle
// the quotient comes from a restoring divider with one quotient bit per pipeline stage,
//   VALUE_BITS + 2 stages, which sets the depth; busy stays low and results cannot be held off
// synchronous reset clears all pipeline valid bits and restores the default calibration table
`default_nettype none

module piecewise_linear_error_correction_top #(
  parameter int MAX_POINTS = 6,
  parameter int VALUE_BITS = 28
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  psel,
  input  wire                                  penable,
  input  wire                                  pwrite,
  input  wire  [plec_pkg::CFG_ADDR_W-1:0]      paddr,
  input  wire  [plec_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [plec_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                 pready,
  input  wire                                  start,
  output logic                                 busy,
  input  wire  [VALUE_BITS-1:0]                in_indicated,
  output logic                                 out_strobe,
  output logic signed [VALUE_BITS+1:0]         out_corrected,
  output logic                                 out_bad_segment,
  output logic                                 out_saturated
);

  import plec_pkg::*;

  localparam int V     = VALUE_BITS;
  localparam int Q     = V + 2;
  localparam int NSEG  = MAX_POINTS - 1;
  localparam int LAT   = Q + 7;

  localparam logic signed [V+3:0] LO_LIM  = (V+4)'(-(64'sd1 <<< V));
  localparam logic signed [V+3:0] HI_LIM  = (V+4)'((64'sd1 <<< (V + 1)) - 64'sd1);
  localparam logic signed [V+1:0] OUT_LO  = (V+2)'(LO_LIM);
  localparam logic signed [V+1:0] OUT_HI  = (V+2)'(HI_LIM);

  // ---------------------------------------------------------------- configuration
  logic [PTS_USED_W-1:0] pts_used_r;
  logic [2*V-1:0]        point_r [MAX_POINTS];
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic                  cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[CFG_ADDR_W-1:CFG_OFS_W];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pts_used_r <= PTS_USED_RESET;
      for (int k = 0; k < MAX_POINTS; k++) begin
        point_r[k] <= PT_RESET_WORD[k][2*V-1:0];
      end
    end else if (cfg_wr) begin
      if (cfg_idx == REG_POINTS_USED) begin
        pts_used_r <= pwdata[PTS_USED_W-1:0];
      end
      for (int k = 0; k < MAX_POINTS; k++) begin
        if (cfg_idx == CFG_IDX_W'(int'(REG_POINT_0) + k)) begin
          point_r[k] <= pwdata[2*V-1:0];
        end
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (cfg_idx == REG_POINTS_USED) begin
      prdata = CFG_DATA_W'(pts_used_r);
    end
    for (int k = 0; k < MAX_POINTS; k++) begin
      if (cfg_idx == CFG_IDX_W'(int'(REG_POINT_0) + k)) begin
        prdata = CFG_DATA_W'(point_r[k]);
      end
    end
  end

  logic [V-1:0]          pt_x [MAX_POINTS];
  logic [V-1:0]          pt_y [MAX_POINTS];
  logic [PTS_USED_W-1:0] used_c;

  always_comb begin
    for (int k = 0; k < MAX_POINTS; k++) begin
      pt_x[k] = point_r[k][2*V-1:V];
      pt_y[k] = point_r[k][V-1:0];
    end
    if (int'(pts_used_r) < 2) begin
      used_c = PTS_USED_W'(2);
    end else if (int'(pts_used_r) > MAX_POINTS) begin
      used_c = PTS_USED_W'(MAX_POINTS);
    end else begin
      used_c = pts_used_r;
    end
  end

  // ---------------------------------------------------------------- stage a: input
  logic         accept;
  logic         a_vld_r;
  logic [V-1:0] a_n_r;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= accept;
    end
    a_n_r <= in_indicated;
  end

  // ---------------------------------------------------------------- stage b: segment select
  logic [NSEG-1:0] seg_sel;
  logic            seg_found;
  logic [V-1:0]    sel_xa, sel_xb, sel_ya, sel_yb;
  logic            b_vld_r;
  logic [V-1:0]    b_n_r, b_xa_r, b_xb_r, b_ya_r, b_yb_r;

  // first segment whose upper point covers the reading, else the last one in use
  always_comb begin
    seg_sel   = '0;
    seg_found = 1'b0;
    for (int k = 0; k < NSEG; k++) begin
      if (!seg_found && ((k + 2) <= int'(used_c)) &&
          ((a_n_r <= pt_x[k+1]) || ((k + 2) == int'(used_c)))) begin
        seg_sel[k] = 1'b1;
        seg_found  = 1'b1;
      end
    end
    sel_xa = '0;
    sel_xb = '0;
    sel_ya = '0;
    sel_yb = '0;
    for (int k = 0; k < NSEG; k++) begin
      sel_xa = sel_xa | ({V{seg_sel[k]}} & pt_x[k]);
      sel_ya = sel_ya | ({V{seg_sel[k]}} & pt_y[k]);
      sel_xb = sel_xb | ({V{seg_sel[k]}} & pt_x[k+1]);
      sel_yb = sel_yb | ({V{seg_sel[k]}} & pt_y[k+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r;
    end
    b_n_r  <= a_n_r;
    b_xa_r <= sel_xa;
    b_xb_r <= sel_xb;
    b_ya_r <= sel_ya;
    b_yb_r <= sel_yb;
  end

  // ---------------------------------------------------------------- stage c: differences
  logic                c_vld_r;
  logic [V-1:0]        c_n_r;
  logic signed [V:0]   c_dx_r, c_ea_r, c_eb_r, c_dn_r;
  logic                c_bad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else begin
      c_vld_r <= b_vld_r;
    end
    c_n_r   <= b_n_r;
    c_dx_r  <= $signed({1'b0, b_xb_r}) - $signed({1'b0, b_xa_r});
    c_ea_r  <= $signed({1'b0, b_ya_r}) - $signed({1'b0, b_xa_r});
    c_eb_r  <= $signed({1'b0, b_yb_r}) - $signed({1'b0, b_xb_r});
    c_dn_r  <= $signed({1'b0, b_n_r}) - $signed({1'b0, b_xa_r});
    c_bad_r <= (b_xb_r == b_xa_r);
  end

  // ---------------------------------------------------------------- stage d: error slope terms
  logic                d_vld_r;
  logic signed [V+1:0] d_de_r, d_base_r;
  logic signed [V:0]   d_dn_r;
  logic [V-1:0]        d_den_r;
  logic                d_dxneg_r, d_bad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else begin
      d_vld_r <= c_vld_r;
    end
    d_de_r    <= (V+2)'(c_ea_r) - (V+2)'(c_eb_r);
    d_base_r  <= $signed({2'b00, c_n_r}) + (V+2)'(c_ea_r);
    d_dn_r    <= c_dn_r;
    d_den_r   <= c_dx_r[V] ? V'(-c_dx_r) : V'(c_dx_r);
    d_dxneg_r <= c_dx_r[V];
    d_bad_r   <= c_bad_r;
  end

  // ---------------------------------------------------------------- stage m: multiply
  logic                  m_vld_r;
  logic signed [2*V+2:0] m_prod_r;
  logic signed [V+1:0]   m_base_r;
  logic [V-1:0]          m_den_r;
  logic                  m_dxneg_r, m_bad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else begin
      m_vld_r <= d_vld_r;
    end
    m_prod_r  <= d_de_r * d_dn_r;
    m_base_r  <= d_base_r;
    m_den_r   <= d_den_r;
    m_dxneg_r <= d_dxneg_r;
    m_bad_r   <= d_bad_r;
  end

  // ---------------------------------------------------------------- divider pipeline
  // entry 0 holds the magnitudes, entry i+1 the state after quotient step i
  logic                prod_abs [1];
  logic signed [2*V+2:0] e_abs;

  logic                dv_vld  [Q+1];
  logic [V-1:0]        dv_rem  [Q+1];
  logic [Q-1:0]        dv_nq   [Q+1];   // dividend bits shift out as quotient bits shift in
  logic [V-1:0]        dv_den  [Q+1];
  logic                dv_qneg [Q+1];
  logic                dv_ovf  [Q+1];
  logic signed [V+1:0] dv_base [Q+1];
  logic                dv_bad  [Q+1];

  logic [V:0]          st_t    [Q];
  logic [V:0]          st_diff [Q];
  logic                st_ge   [Q];
  logic [V-1:0]        st_rem  [Q];
  logic [Q-1:0]        st_nq   [Q];
  logic                st_ovf  [Q];

  always_comb begin
    prod_abs[0] = m_prod_r[2*V+2];
    e_abs       = prod_abs[0] ? -m_prod_r : m_prod_r;
  end

  always_comb begin
    for (int i = 0; i < Q; i++) begin
      st_t[i]    = {dv_rem[i], dv_nq[i][Q-1]};
      st_diff[i] = st_t[i] - {1'b0, dv_den[i]};
      st_ge[i]   = (st_t[i] >= {1'b0, dv_den[i]});
      st_rem[i]  = st_ge[i] ? st_diff[i][V-1:0] : st_t[i][V-1:0];
      st_nq[i]   = {dv_nq[i][Q-2:0], st_ge[i]};
      // quotient needs more than Q bits when the high dividend part reaches the divisor
      if (i == 0) begin
        st_ovf[i] = (dv_rem[i] >= dv_den[i]);
      end else begin
        st_ovf[i] = dv_ovf[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= Q; i++) begin
        dv_vld[i] <= 1'b0;
      end
    end else begin
      dv_vld[0] <= m_vld_r;
      for (int i = 0; i < Q; i++) begin
        dv_vld[i+1] <= dv_vld[i];
      end
    end
    dv_rem[0]  <= V'(e_abs[2*V:Q]);
    dv_nq[0]   <= e_abs[Q-1:0];
    dv_den[0]  <= m_den_r;
    dv_qneg[0] <= prod_abs[0] ^ m_dxneg_r;
    dv_ovf[0]  <= 1'b0;
    dv_base[0] <= m_base_r;
    dv_bad[0]  <= m_bad_r;
    for (int i = 0; i < Q; i++) begin
      dv_rem[i+1]  <= st_rem[i];
      dv_nq[i+1]   <= st_nq[i];
      dv_den[i+1]  <= dv_den[i];
      dv_qneg[i+1] <= dv_qneg[i];
      dv_ovf[i+1]  <= st_ovf[i];
      dv_base[i+1] <= dv_base[i];
      dv_bad[i+1]  <= dv_bad[i];
    end
  end

  // ---------------------------------------------------------------- stage f: sum and clip
  logic signed [V+2:0]  q_s;
  logic signed [V+3:0]  r_s;
  logic signed [V+1:0]  corr_nxt;
  logic                 sat_nxt;

  always_comb begin
    q_s = dv_qneg[Q] ? -$signed({1'b0, dv_nq[Q]}) : $signed({1'b0, dv_nq[Q]});
    r_s = (V+4)'(dv_base[Q]) - (V+4)'(q_s);
    if (dv_bad[Q]) begin
      corr_nxt = '0;
      sat_nxt  = 1'b0;
    end else if (dv_ovf[Q]) begin
      // quotient magnitude beyond any in-range result: clip by its sign
      corr_nxt = dv_qneg[Q] ? OUT_HI : OUT_LO;
      sat_nxt  = 1'b1;
    end else if (r_s < LO_LIM) begin
      corr_nxt = OUT_LO;
      sat_nxt  = 1'b1;
    end else if (r_s > HI_LIM) begin
      corr_nxt = OUT_HI;
      sat_nxt  = 1'b1;
    end else begin
      corr_nxt = (V+2)'(r_s);
      sat_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= dv_vld[Q];
    end
    out_corrected   <= corr_nxt;
    out_bad_segment <= dv_bad[Q];
    out_saturated   <= sat_nxt;
  end

  // ---------------------------------------------------------------- assertions
  a_strobe_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, LAT))
    else $error("result strobe without a matching accepted transaction");

  a_bad_segment_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_bad_segment) |-> (out_corrected == '0 && !out_saturated))
    else $error("zero-width segment must give zero and no clip");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_saturated) |-> (out_corrected == OUT_LO || out_corrected == OUT_HI))
    else $error("clipped result is not at a range limit");

  a_result_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_corrected >= OUT_LO))
    else $error("corrected value below range");

endmodule

`default_nettype wire
